### hdl/dfs_pkg.sv
// ---------------------------------------------------------------------------
// dfs_pkg: shared types for the topological sort core
// Field widths shared across the block.
// ---------------------------------------------------------------------------
package dfs_pkg;
   localparam int NODE_W  = 4;
   localparam int COUNT_W = 5;

   typedef logic [NODE_W-1:0] node_type;
endpackage

### hdl/dfs_if.sv
// ---------------------------------------------------------------------------
// dfs_req_if / dfs_rsp_if: request and response channels
// Valid/ready handshake with payload.
// ---------------------------------------------------------------------------
interface dfs_req_if;
   logic               valid;
   logic               ready;
   dfs_pkg::node_type  edge_from;
   dfs_pkg::node_type  edge_to;
   logic               both_ways;
   logic               last_edge;
   modport source (output valid, edge_from, edge_to, both_ways, last_edge, input ready);
   modport sink   (input valid, edge_from, edge_to, both_ways, last_edge, output ready);
endinterface

interface dfs_rsp_if;
   logic               valid;
   logic               ready;
   dfs_pkg::node_type  node_id;
   logic               last_node;
   logic               edges_dropped;
   modport source (output valid, node_id, last_node, edges_dropped, input ready);
   modport sink   (input valid, node_id, last_node, edges_dropped, output ready);
endinterface

### hdl/dfs_ram.sv
// ---------------------------------------------------------------------------
// dfs_ram: generic single-port-write RAM
// One write port, one registered read port.
// ---------------------------------------------------------------------------
module dfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### hdl/dfs_topological_sort_core.sv
// Edge load: each request is taken in S_LOAD; with both_ways, S_REV also stores the reverse edge.
// Last request: each start node is tried in S_START; a walk runs S_NODE, S_RDWAIT, S_SCAN
//   per stack step and S_RDWAIT, S_SCAN per edge skipped in the scan (edge store read is
//   registered); responses then go out, held while stalled, and S_CLEAR follows.
// Throughput: one graph at a time; request ready is low during walk and emit.
// Reset: synchronous active high; clears edge count, overflow, visited marks,
//   sets node_count to 8. No clearing pass.
// ---------------------------------------------------------------------------
// dfs_topological_sort_core: depth-first topological sort over loaded edges
// Loads edges into a RAM, then walks them with one scan sequencer.
// ---------------------------------------------------------------------------
module dfs_topological_sort_core #(
   parameter int NODES     = 16,
   parameter int MAX_EDGES = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   dfs_req_if.sink                 req,
   dfs_rsp_if.source               rsp,
   input  logic                    csr_wr_en,
   input  logic [dfs_pkg::COUNT_W-1:0] csr_wr_data
);
   import dfs_pkg::*;

   localparam int EA_W = $clog2(MAX_EDGES);
   localparam int EC_W = $clog2(MAX_EDGES + 1);
   localparam int NA_W = $clog2(NODES);
   localparam int NC_W = $clog2(NODES + 1);

   typedef enum logic [3:0] {
      S_LOAD, S_REV, S_START, S_NODE, S_RDWAIT, S_SCAN, S_EMIT, S_CLEAR
   } state_type;

   state_type           state_ff;
   logic [COUNT_W-1:0]  node_count_ff;
   logic [EC_W-1:0]     held_ff;
   logic                ovf_ff;
   logic [NODES-1:0]    visited_ff;
   logic [NODE_W-1:0]   rev_from_ff, rev_to_ff;
   logic                rev_last_ff;
   logic [NC_W-1:0]     start_ff;
   logic [NC_W-1:0]     depth_ff;
   logic [NC_W-1:0]     fin_ff;
   logic [NODE_W-1:0]   node_stk_ff [NODES];
   logic [EC_W-1:0]     pos_stk_ff  [NODES];
   logic [NODE_W-1:0]   fin_stk_ff  [NODES];
   logic [NODE_W-1:0]   cur_node_ff;
   logic [EC_W-1:0]     scan_ff;
   logic                rsp_valid_ff;
   logic [NODE_W-1:0]   rsp_node_ff;
   logic                rsp_last_ff, rsp_drop_ff;

   // edge store, both lists packed in one word
   logic                ram_we;
   logic [EA_W-1:0]     ram_waddr, ram_raddr;
   logic [2*NODE_W-1:0] ram_wdata, ram_rdata;

   dfs_ram #(.WIDTH(2*NODE_W), .DEPTH(MAX_EDGES)) u_edges (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ram_wdata),
      .rd_addr(ram_raddr), .rd_data(ram_rdata)
   );

   logic [NC_W-1:0] starts;
   logic            from_ok, to_ok, fits;
   logic [NODE_W-1:0] e_src, e_dst;
   logic [NC_W-1:0] top;

   function automatic logic [NA_W-1:0] top_fin(input logic [NC_W-1:0] f);
      logic [NC_W-1:0] t;
      t = f - NC_W'(1);
      return t[NA_W-1:0];
   endfunction

   assign starts  = ({{(NC_W > COUNT_W ? NC_W-COUNT_W : 1){1'b0}}, node_count_ff} > NODES)
                    ? NC_W'(NODES) : NC_W'(node_count_ff);
   assign from_ok = (state_ff == S_LOAD) ? (32'(req.edge_from) < NODES)
                                          : (32'(rev_from_ff) < NODES);
   assign to_ok   = (state_ff == S_LOAD) ? (32'(req.edge_to) < NODES)
                                          : (32'(rev_to_ff) < NODES);
   assign fits    = held_ff < EC_W'(MAX_EDGES);
   assign e_src   = ram_rdata[2*NODE_W-1:NODE_W];
   assign e_dst   = ram_rdata[NODE_W-1:0];
   assign top     = depth_ff - NC_W'(1);
   assign req.ready = (state_ff == S_LOAD);

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = held_ff[EA_W-1:0];
      ram_wdata = {req.edge_from, req.edge_to};
      if (state_ff == S_LOAD) begin
         ram_we = req.valid && from_ok && to_ok && fits;
      end else if (state_ff == S_REV) begin
         ram_we    = from_ok && to_ok && fits;
         ram_wdata = {rev_from_ff, rev_to_ff};
      end
      ram_raddr = scan_ff[EA_W-1:0];
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.node_id       = rsp_node_ff;
   assign rsp.last_node     = rsp_last_ff;
   assign rsp.edges_dropped = rsp_drop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         node_count_ff <= COUNT_W'(8);
         held_ff       <= '0;
         ovf_ff        <= 1'b0;
         visited_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            node_count_ff <= csr_wr_data;
         end
         // drop a taken response; the emit state handles its own slot
         if (rsp_valid_ff && rsp.ready && state_ff != S_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_LOAD: begin
               if (req.valid) begin
                  // store forward edge, flag overflow
                  if (from_ok && to_ok) begin
                     if (fits) held_ff <= held_ff + EC_W'(1);
                     else      ovf_ff  <= 1'b1;
                  end
                  rev_from_ff <= req.edge_to;
                  rev_to_ff   <= req.edge_from;
                  rev_last_ff <= req.last_edge;
                  start_ff    <= '0;
                  fin_ff      <= '0;
                  if (req.both_ways)      state_ff <= S_REV;
                  else if (req.last_edge) state_ff <= S_START;
               end
            end
            S_REV: begin
               if (from_ok && to_ok) begin
                  if (fits) held_ff <= held_ff + EC_W'(1);
                  else      ovf_ff  <= 1'b1;
               end
               state_ff <= rev_last_ff ? S_START : S_LOAD;
            end
            S_START: begin
               // try next start node in ascending order
               if (start_ff >= starts) begin
                  state_ff <= (fin_ff != '0) ? S_EMIT : S_CLEAR;
               end else begin
                  if (!visited_ff[start_ff[NA_W-1:0]]) begin
                     visited_ff[start_ff[NA_W-1:0]] <= 1'b1;
                     node_stk_ff[0] <= NODE_W'(start_ff);
                     pos_stk_ff[0]  <= '0;
                     depth_ff       <= NC_W'(1);
                     state_ff       <= S_NODE;
                  end
                  start_ff <= start_ff + NC_W'(1);
               end
            end
            S_NODE: begin
               // resume scan of top-of-stack node
               if (depth_ff == '0) begin
                  state_ff <= S_START;
               end else begin
                  cur_node_ff <= node_stk_ff[top[NA_W-1:0]];
                  scan_ff     <= pos_stk_ff[top[NA_W-1:0]];
                  state_ff    <= S_RDWAIT;
               end
            end
            S_RDWAIT: begin
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               if (scan_ff >= held_ff) begin
                  // node finished: push to finish stack, pop
                  if (fin_ff < NC_W'(NODES)) begin
                     fin_stk_ff[fin_ff[NA_W-1:0]] <= cur_node_ff;
                     fin_ff <= fin_ff + NC_W'(1);
                  end
                  depth_ff <= top;
                  state_ff <= S_NODE;
               end else if (e_src == cur_node_ff) begin
                  pos_stk_ff[top[NA_W-1:0]] <= scan_ff + EC_W'(1);
                  if (32'(e_dst) < NODES && !visited_ff[NA_W'(e_dst)]
                      && depth_ff < NC_W'(NODES)) begin
                     visited_ff[NA_W'(e_dst)]        <= 1'b1;
                     node_stk_ff[depth_ff[NA_W-1:0]] <= e_dst;
                     pos_stk_ff[depth_ff[NA_W-1:0]]  <= '0;
                     depth_ff <= depth_ff + NC_W'(1);
                  end
                  state_ff <= S_NODE;
               end else begin
                  // advance scan; read for next address is issued from S_RDWAIT
                  scan_ff  <= scan_ff + EC_W'(1);
                  state_ff <= S_RDWAIT;
               end
            end
            S_EMIT: begin
               // pop finish stack, one response at a time
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_node_ff  <= fin_stk_ff[top_fin(fin_ff)];
                  rsp_last_ff  <= (fin_ff == NC_W'(1));
                  rsp_drop_ff  <= ovf_ff;
                  fin_ff       <= fin_ff - NC_W'(1);
                  if (fin_ff == NC_W'(1)) state_ff <= S_CLEAR;
               end
            end
            S_CLEAR: begin
               held_ff    <= '0;
               ovf_ff     <= 1'b0;
               visited_ff <= '0;
               state_ff   <= S_LOAD;
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end
endmodule

### hdl/dfs_checker.sv
// ---------------------------------------------------------------------------
// dfs_checker: port-level checks for the sort core
// Watches handshakes and response fields.
// ---------------------------------------------------------------------------
module dfs_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [3:0] rsp_node_id,
   input logic rsp_last_node
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_node_id))
      else $error("response dropped while stalled");
   a_no_req_during_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_node |-> !req_ready)
      else $error("request accepted mid-order");
   a_ready_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_ready)
      else $error("not ready after reset");
endmodule

bind dfs_topological_sort_core dfs_checker u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_node_id(rsp.node_id), .rsp_last_node(rsp.last_node)
);
